// ===== src/lid_pkg.sv =====
// Shared types, widths and opcode keys for the LEGv8 instruction decoder.
package lid_pkg;

  localparam int unsigned InstrW   = 32;
  localparam int unsigned OpcodeW  = 11;
  localparam int unsigned TypeW    = 3;
  localparam int unsigned OutDataW = 104;

  // Instruction format codes
  typedef enum logic [TypeW-1:0] {
    TYPE_R       = 3'd0,
    TYPE_I       = 3'd1,
    TYPE_D       = 3'd2,
    TYPE_B       = 3'd3,
    TYPE_CB      = 3'd4,
    TYPE_UNKNOWN = 3'd5
  } inst_type_t;

  // Opcode keys, one group per prefix width
  localparam logic [5:0]  OP_B      = 6'b000101;
  localparam logic [5:0]  OP_BL     = 6'b100101;
  localparam logic [7:0]  OP_BCOND  = 8'b01010100;
  localparam logic [7:0]  OP_CBNZ   = 8'b10110101;
  localparam logic [7:0]  OP_CBZ    = 8'b10110100;
  localparam logic [9:0]  OP_ADDI   = 10'b1001000100;
  localparam logic [9:0]  OP_ANDI   = 10'b1001001000;
  localparam logic [9:0]  OP_EORI   = 10'b1101001000;
  localparam logic [9:0]  OP_ORRI   = 10'b1011001000;
  localparam logic [9:0]  OP_SUBI   = 10'b1101000100;
  localparam logic [9:0]  OP_SUBIS  = 10'b1111000100;
  localparam logic [10:0] OP_ADD    = 11'b10001011000;
  localparam logic [10:0] OP_AND    = 11'b10001010000;
  localparam logic [10:0] OP_BR     = 11'b11010110000;
  localparam logic [10:0] OP_EOR    = 11'b11001010000;
  localparam logic [10:0] OP_LDUR   = 11'b11111000010;
  localparam logic [10:0] OP_LSL    = 11'b11010011011;
  localparam logic [10:0] OP_LSR    = 11'b11010011010;
  localparam logic [10:0] OP_MUL    = 11'b10011011000;
  localparam logic [10:0] OP_ORR    = 11'b10101010000;
  localparam logic [10:0] OP_STUR   = 11'b11111000000;
  localparam logic [10:0] OP_SUB    = 11'b11001011000;
  localparam logic [10:0] OP_SUBS   = 11'b11101011000;
  localparam logic [10:0] OP_PRNT   = 11'b11111111101;
  localparam logic [10:0] OP_PRNL   = 11'b11111111100;
  localparam logic [10:0] OP_DUMP   = 11'b11111111110;
  localparam logic [10:0] OP_HALT   = 11'b11111111111;

  // One decoded instruction
  typedef struct packed {
    inst_type_t          inst_type;
    logic [OpcodeW-1:0]  opcode;
    logic [4:0]          rd_rt;
    logic [4:0]          rn;
    logic [5:0]          shamt;
    logic [4:0]          rm;
    logic signed [11:0]  alu_imm;
    logic signed [25:0]  br_offset;
    logic [8:0]          dt_offset;
    logic signed [18:0]  cb_offset;
    logic                dt_op;
  } dec_t;

endpackage

// ===== src/lid_pipe_reg.sv =====
// One valid/ready pipeline register stage with a held payload.
module lid_pipe_reg #(
  parameter int unsigned Width = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             s_valid,
  output logic             s_ready,
  input  logic [Width-1:0] s_data,
  output logic             m_valid,
  input  logic             m_ready,
  output logic [Width-1:0] m_data
);

  logic             valid_r;
  logic             valid_nxt;
  logic [Width-1:0] data_r;

  // Take a new request when empty or when the held one leaves this cycle
  assign s_ready   = !valid_r || m_ready;
  assign valid_nxt = s_ready ? s_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Load payload on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      data_r <= s_data;
    end
  end

  assign m_valid = valid_r;
  assign m_data  = data_r;

endmodule

// ===== src/lid_decode.sv =====
// Format classification and field extraction for one instruction word.
module lid_decode (
  input  logic [lid_pkg::InstrW-1:0] instr_word,
  output lid_pkg::dec_t              dec
);
  import lid_pkg::*;

  logic [5:0]  pre6;
  logic [7:0]  pre8;
  logic [9:0]  pre10;
  logic [10:0] pre11;
  inst_type_t  kind;

  assign pre6  = instr_word[31:26];
  assign pre8  = instr_word[31:24];
  assign pre10 = instr_word[31:22];
  assign pre11 = instr_word[31:21];

  // Match prefixes, shortest width first
  always_comb begin
    if (pre6 inside {OP_B, OP_BL}) begin
      kind = TYPE_B;
    end else if (pre8 inside {OP_BCOND, OP_CBNZ, OP_CBZ}) begin
      kind = TYPE_CB;
    end else if (pre10 inside {OP_ADDI, OP_ANDI, OP_EORI, OP_ORRI, OP_SUBI, OP_SUBIS}) begin
      kind = TYPE_I;
    end else if (pre11 inside {OP_LDUR, OP_STUR}) begin
      kind = TYPE_D;
    end else if (pre11 inside {OP_ADD, OP_AND, OP_BR, OP_EOR, OP_LSL, OP_LSR, OP_MUL,
                               OP_ORR, OP_SUB, OP_SUBS, OP_PRNT, OP_PRNL, OP_DUMP,
                               OP_HALT}) begin
      kind = TYPE_R;
    end else begin
      kind = TYPE_UNKNOWN;
    end
  end

  // Right-align the opcode at the width of its format
  always_comb begin
    dec.inst_type = kind;
    case (kind)
      TYPE_I:  dec.opcode = {1'b0, pre10};
      TYPE_B:  dec.opcode = {5'b0, pre6};
      TYPE_CB: dec.opcode = {3'b0, pre8};
      default: dec.opcode = pre11;
    endcase
    dec.rd_rt     = instr_word[4:0];
    dec.rn        = instr_word[9:5];
    dec.shamt     = instr_word[15:10];
    dec.rm        = instr_word[20:16];
    dec.alu_imm   = instr_word[21:10];
    dec.br_offset = instr_word[25:0];
    dec.dt_offset = instr_word[20:12];
    dec.cb_offset = instr_word[23:5];
    dec.dt_op     = instr_word[10];
  end

endmodule

// ===== src/legv8_instruction_decoder_top.sv =====
// Path: an accepted word is held in the input register, decoded combinationally, then loaded into the result register.
// Throughput: one instruction per cycle while out_tready is high; decode is a single combinational pass.
// Each stage loads when empty or when its request leaves; input stalls only with both full.
// Reset: synchronous active-low rst_n empties both stages; payload is not cleared.
// Top level of the LEGv8 instruction decoder.
module legv8_instruction_decoder_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [lid_pkg::InstrW-1:0]     in_tdata,   // [31:0] instr_word
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [lid_pkg::OutDataW-1:0]   out_tdata,  // opcode[10:0] rd_rt[15:11] rn[20:16]
                                                     // shamt[26:21] rm[31:27] alu_imm[43:32]
                                                     // br_offset[69:44] dt_offset[78:70]
                                                     // cb_offset[97:79] dt_op[98] zero[103:99]
  output logic [lid_pkg::TypeW-1:0]      out_tuser   // [2:0] inst_type
);
  import lid_pkg::*;

  logic              word_valid;
  logic              word_ready;
  logic [InstrW-1:0] word;
  dec_t              dec;
  dec_t              res;

  // Input register
  lid_pipe_reg #(
    .Width (InstrW)
  ) u_in_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (in_tvalid),
    .s_ready (in_tready),
    .s_data  (in_tdata),
    .m_valid (word_valid),
    .m_ready (word_ready),
    .m_data  (word)
  );

  // Decode
  lid_decode u_decode (
    .instr_word (word),
    .dec        (dec)
  );

  // Result register
  lid_pipe_reg #(
    .Width ($bits(dec_t))
  ) u_out_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (word_valid),
    .s_ready (word_ready),
    .s_data  (dec),
    .m_valid (out_tvalid),
    .m_ready (out_tready),
    .m_data  (res)
  );

  // Pack result fields, lowest first
  assign out_tuser = res.inst_type;
  assign out_tdata = {5'b0, res.dt_op, res.cb_offset, res.dt_offset, res.br_offset,
                      res.alu_imm, res.rm, res.shamt, res.rn, res.rd_rt, res.opcode};

`ifndef SYNTH
  // Format code stays within the defined set
  a_type_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= TYPE_UNKNOWN)
    else $error("inst_type out of range");

  // Branch opcode uses only six bits
  a_b_opcode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == TYPE_B) |-> out_tdata[10:6] == 5'b0)
    else $error("B opcode wider than six bits");

  // A draining pipeline never blocks the input
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output drains");

  // An accepted word reaches the result register when the output side is open
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (word_valid && word_ready) |=> out_tvalid)
    else $error("decoded request lost");
`endif

endmodule

// ===== tb/legv8_instruction_decoder_top_test.sv =====
// Stream testbench for the LEGv8 instruction decoder: directed opcode table, random words.
`timescale 1ns / 1ps

module legv8_instruction_decoder_top_test;
  import lid_pkg::*;

  // One directed request: word plus its format and opcode as read off the key
  typedef struct packed {
    logic [31:0] word;
    inst_type_t  kind;
    logic [10:0] opc;
  } directed_row_t;

  localparam int unsigned NumOps = 27;
  localparam int unsigned NumDirected = 30;
  localparam int unsigned RandPerPhase = 364;

  // Every opcode key right-aligned, with its prefix width
  localparam logic [10:0] OpKeys [NumOps] = '{
    11'(OP_B), 11'(OP_BL), 11'(OP_BCOND), 11'(OP_CBNZ), 11'(OP_CBZ),
    11'(OP_ADDI), 11'(OP_ANDI), 11'(OP_EORI), 11'(OP_ORRI), 11'(OP_SUBI), 11'(OP_SUBIS),
    OP_ADD, OP_AND, OP_BR, OP_EOR, OP_LDUR, OP_LSL, OP_LSR, OP_MUL, OP_ORR, OP_STUR,
    OP_SUB, OP_SUBS, OP_PRNT, OP_PRNL, OP_DUMP, OP_HALT
  };
  localparam int unsigned OpWidths [NumOps] = '{
    6, 6, 8, 8, 8, 10, 10, 10, 10, 10, 10,
    11, 11, 11, 11, 11, 11, 11, 11, 11, 11, 11, 11, 11, 11, 11, 11
  };

  // Extremes of the fields, every opcode, and near misses of the prefix match
  localparam directed_row_t DirectedRows [NumDirected] = '{
    '{32'h0000_0000,                 TYPE_UNKNOWN, 11'h000},
    '{32'hFFFF_FFFF,                 TYPE_R,       OP_HALT},
    '{{OP_B,      26'h3FF_FFFF},     TYPE_B,       11'(OP_B)},
    '{{OP_BL,     26'h000_0000},     TYPE_B,       11'(OP_BL)},
    '{{OP_BCOND,  24'h80_001F},      TYPE_CB,      11'(OP_BCOND)},
    '{{OP_CBNZ,   24'h7F_FFE0},      TYPE_CB,      11'(OP_CBNZ)},
    '{{OP_CBZ,    24'h00_0000},      TYPE_CB,      11'(OP_CBZ)},
    '{{OP_ADDI,   22'h20_03FF},      TYPE_I,       11'(OP_ADDI)},
    '{{OP_ANDI,   22'h1F_FC00},      TYPE_I,       11'(OP_ANDI)},
    '{{OP_EORI,   22'h15_5555},      TYPE_I,       11'(OP_EORI)},
    '{{OP_ORRI,   22'h2A_AAAA},      TYPE_I,       11'(OP_ORRI)},
    '{{OP_SUBI,   22'h3F_FFFF},      TYPE_I,       11'(OP_SUBI)},
    '{{OP_SUBIS,  22'h00_0000},      TYPE_I,       11'(OP_SUBIS)},
    '{{OP_ADD,    21'h1F_FFFF},      TYPE_R,       OP_ADD},
    '{{OP_AND,    21'h00_0000},      TYPE_R,       OP_AND},
    '{{OP_BR,     21'h00_03E0},      TYPE_R,       OP_BR},
    '{{OP_EOR,    21'h15_5555},      TYPE_R,       OP_EOR},
    '{{OP_LDUR,   21'h1F_F000},      TYPE_D,       OP_LDUR},
    '{{OP_LSL,    21'h0A_AAAA},      TYPE_R,       OP_LSL},
    '{{OP_LSR,    21'h1F_FFFF},      TYPE_R,       OP_LSR},
    '{{OP_MUL,    21'h00_FC00},      TYPE_R,       OP_MUL},
    '{{OP_ORR,    21'h1F_0000},      TYPE_R,       OP_ORR},
    '{{OP_STUR,   21'h00_0400},      TYPE_D,       OP_STUR},
    '{{OP_SUB,    21'h12_3456},      TYPE_R,       OP_SUB},
    '{{OP_SUBS,   21'h0F_EDCB},      TYPE_R,       OP_SUBS},
    '{{OP_PRNT,   21'h00_0000},      TYPE_R,       OP_PRNT},
    '{{OP_PRNL,   21'h1F_FFFF},      TYPE_R,       OP_PRNL},
    '{{OP_DUMP,   21'h05_A5A5},      TYPE_R,       OP_DUMP},
    // 11-bit prefix equal in value to a 6-bit key must not match it
    '{{11'h005,   21'h1F_FFFF},      TYPE_UNKNOWN, 11'h005},
    // one step away from the load/store keys
    '{{11'h7C1,   21'h00_0000},      TYPE_UNKNOWN, 11'h7C1}
  };

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [InstrW-1:0]    in_tdata = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OutDataW-1:0]  out_tdata;
  logic [TypeW-1:0]     out_tuser;

  int unsigned   send_idle_pct = 0;
  int unsigned   recv_stall_pct = 0;
  int unsigned   fail_count = 0;
  dec_t          decoded_q [$];

  legv8_instruction_decoder_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Decode one word: shortest matching prefix wins, then slice every field
  function automatic dec_t decode_word(input logic [31:0] w);
    dec_t d;
    logic [5:0]  p6;
    logic [7:0]  p8;
    logic [9:0]  p10;
    logic [10:0] p11;
    p6 = w[31:26];
    p8 = w[31:24];
    p10 = w[31:22];
    p11 = w[31:21];
    if (p6 == OP_B || p6 == OP_BL) begin
      d.inst_type = TYPE_B;
    end else if (p8 == OP_BCOND || p8 == OP_CBNZ || p8 == OP_CBZ) begin
      d.inst_type = TYPE_CB;
    end else if (p10 == OP_ADDI || p10 == OP_ANDI || p10 == OP_EORI || p10 == OP_ORRI ||
                 p10 == OP_SUBI || p10 == OP_SUBIS) begin
      d.inst_type = TYPE_I;
    end else if (p11 == OP_LDUR || p11 == OP_STUR) begin
      d.inst_type = TYPE_D;
    end else if (p11 == OP_ADD || p11 == OP_AND || p11 == OP_BR || p11 == OP_EOR ||
                 p11 == OP_LSL || p11 == OP_LSR || p11 == OP_MUL || p11 == OP_ORR ||
                 p11 == OP_SUB || p11 == OP_SUBS || p11 == OP_PRNT || p11 == OP_PRNL ||
                 p11 == OP_DUMP || p11 == OP_HALT) begin
      d.inst_type = TYPE_R;
    end else begin
      d.inst_type = TYPE_UNKNOWN;
    end
    case (d.inst_type)
      TYPE_I:  d.opcode = {1'b0, p10};
      TYPE_B:  d.opcode = {5'b0, p6};
      TYPE_CB: d.opcode = {3'b0, p8};
      default: d.opcode = p11;
    endcase
    d.rd_rt     = w[4:0];
    d.rn        = w[9:5];
    d.shamt     = w[15:10];
    d.rm        = w[20:16];
    d.alu_imm   = w[21:10];
    d.br_offset = w[25:0];
    d.dt_offset = w[20:12];
    d.cb_offset = w[23:5];
    d.dt_op     = w[10];
    return d;
  endfunction

  // Offer one request after a random gap; hold until accepted, then queue its decode
  task automatic send_word(input logic [31:0] w, input dec_t want);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= $urandom;
      @(negedge clk);
    end
    in_tdata  <= w;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    decoded_q.push_back(want);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Stall the result side at random
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each accepted result with the oldest decode waiting
  always @(posedge clk) begin
    dec_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: result with none expected, actual tuser 0x%0h tdata 0x%0h",
                 $time, out_tuser, out_tdata);
        fail_count++;
      end else begin
        want = decoded_q.pop_front();
        check_field("inst_type", 32'(want.inst_type), 32'(out_tuser));
        check_field("opcode",    32'(want.opcode),    32'(out_tdata[10:0]));
        check_field("rd_rt",     32'(want.rd_rt),     32'(out_tdata[15:11]));
        check_field("rn",        32'(want.rn),        32'(out_tdata[20:16]));
        check_field("shamt",     32'(want.shamt),     32'(out_tdata[26:21]));
        check_field("rm",        32'(want.rm),        32'(out_tdata[31:27]));
        check_field("alu_imm",   32'(unsigned'(want.alu_imm)),   32'(out_tdata[43:32]));
        check_field("br_offset", 32'(unsigned'(want.br_offset)), 32'(out_tdata[69:44]));
        check_field("dt_offset", 32'(want.dt_offset), 32'(out_tdata[78:70]));
        check_field("cb_offset", 32'(unsigned'(want.cb_offset)), 32'(out_tdata[97:79]));
        check_field("dt_op",     32'(want.dt_op),     32'(out_tdata[98]));
        check_field("padding",   32'h0,               32'(out_tdata[103:99]));
      end
    end
  end

  // Main sequence: reset, directed table, random phases, drain
  initial begin
    dec_t        want;
    logic [31:0] w;
    int unsigned pick;
    int unsigned width;
    int unsigned sel;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed table: format and opcode as typed, other fields by decode
    for (int i = 0; i < NumDirected; i++) begin
      want = decode_word(DirectedRows[i].word);
      want.inst_type = DirectedRows[i].kind;
      want.opcode    = DirectedRows[i].opc;
      send_word(DirectedRows[i].word, want);
    end

    // Random phases with different idle and stall pressure
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        1:       begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 71; end
        3:       begin send_idle_pct = 11; recv_stall_pct = 11; end
        default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
      for (int n = 0; n < RandPerPhase; n++) begin
        sel   = $urandom_range(99);
        pick  = $urandom_range(NumOps - 1);
        width = OpWidths[pick];
        w     = $urandom;
        if (sel < 80) begin
          // well-formed opcode with random operands
          w = (w & (32'hFFFF_FFFF >> width)) | (32'(OpKeys[pick]) << (32 - width));
          // near miss: flip one bit of the key
          if (sel >= 65) w = w ^ (32'h1 << (31 - $urandom_range(width - 1)));
        end
        send_word(w, decode_word(w));
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    recv_stall_pct = 0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (fail_count == 0) begin
      $display("** legv8_instruction_decoder_top: PASSED **");
    end else begin
      $display("** legv8_instruction_decoder_top: FAILED **");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #5_000_000;
    $display("** legv8_instruction_decoder_top: FAILED **");
    $finish;
  end

endmodule
